// File: hdl/tcsf_pkg.sv
// shared constants, types and control structs of the tiled circle span fill block
package tcsf_pkg;

    // tile edge default and span limit per circle
    localparam int TILE_SIZE_DEF = 32;
    localparam int MAX_SPANS     = 32;
    localparam int CNT_W         = $clog2(MAX_SPANS + 1);

    // field widths
    localparam int POS_W   = 13;
    localparam int RAD_W   = 10;
    localparam int COLOR_W = 32;
    localparam int TIDX_W  = 6;
    localparam int OUT_W   = 11;

    // internal signed coordinate width, covers center +/- radius and tile edges
    localparam int COORD_W = 15;

    // configuration port
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_W-1:0]     FRAME_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0]     FRAME_HEIGHT_RST = CFG_W'(480);

    // square root unit: radicand r*r fits 2*RAD_W bits
    localparam int SQ_IN_W   = 2 * RAD_W;
    localparam int SQ_OUT_W  = RAD_W;
    localparam int SQ_STEPS  = 2;
    localparam int SQ_CYCLES = SQ_OUT_W / SQ_STEPS;
    localparam int SQ_CNT_W  = $clog2(SQ_CYCLES);

    typedef logic signed [COORD_W-1:0] coord_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic setup;
        logic row_init;
        logic dy_calc;
        logic mul;
        logic sq_start;
        logic clip;
        logic push_span;
        logic next_row;
        logic emit_final;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic row_done;
        logic sq_done;
        logic span_hit;
        logic pend_valid;
        logic out_free;
    } dp_stat_t;

endpackage

// File: hdl/tcsf_isqrt.sv
// iterative integer floor square root, two result bits per cycle
module tcsf_isqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tcsf_pkg::SQ_IN_W-1:0]  radicand,
    output logic                          done,
    output logic [tcsf_pkg::SQ_OUT_W-1:0] root
);
    import tcsf_pkg::*;

    localparam int REM_W = SQ_OUT_W + 2;
    localparam int CUR_W = REM_W + 2;

    logic [SQ_IN_W-1:0]  rad_reg;
    logic [REM_W-1:0]    rem_reg,  rem_next;
    logic [SQ_OUT_W-1:0] root_reg, root_next;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    // two restoring steps on the next four radicand bits
    always_comb
    begin
        logic [CUR_W-1:0] cur;
        logic [CUR_W-1:0] trial;
        rem_next  = rem_reg;
        root_next = root_reg;
        for (int i = 0; i < SQ_STEPS; i++)
        begin
            cur   = {rem_next, rad_reg[SQ_IN_W-1-2*i -: 2]};
            trial = {{(REM_W-SQ_OUT_W){1'b0}}, root_next, 2'b01};
            if (cur >= trial)
            begin
                rem_next  = REM_W'(cur - trial);
                root_next = {root_next[SQ_OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(cur);
                root_next = {root_next[SQ_OUT_W-2:0], 1'b0};
            end
        end
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SQ_CNT_W'(SQ_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << (2 * SQ_STEPS);
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: hdl/tcsf_datapath.sv
// datapath: frame registers, tile geometry, row walk, clipping, pending span and output beat
module tcsf_datapath
#(
    parameter int TILE_SIZE = tcsf_pkg::TILE_SIZE_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tcsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcsf_pkg::CFG_W-1:0]          cfg_data,
    input  logic signed [tcsf_pkg::POS_W-1:0]   center_x,
    input  logic signed [tcsf_pkg::POS_W-1:0]   center_y,
    input  logic [tcsf_pkg::RAD_W-1:0]          radius,
    input  logic [tcsf_pkg::COLOR_W-1:0]        fill_color,
    input  logic [tcsf_pkg::TIDX_W-1:0]         tile_col,
    input  logic [tcsf_pkg::TIDX_W-1:0]         tile_row,
    input  tcsf_pkg::dp_cmd_t                   cmd,
    output tcsf_pkg::dp_stat_t                  stat,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tcsf_pkg::OUT_W-1:0]          span_row,
    output logic [tcsf_pkg::OUT_W-1:0]          span_first,
    output logic [tcsf_pkg::OUT_W-1:0]          span_last,
    output logic [tcsf_pkg::COLOR_W-1:0]        span_color,
    output logic                                final_span
);
    import tcsf_pkg::*;

    localparam coord_t TILE_C = coord_t'(TILE_SIZE);

    // frame size registers
    logic [CFG_W-1:0] fw_reg, fh_reg;

    // item registers
    logic signed [POS_W-1:0] cx_reg, cy_reg;
    logic [RAD_W-1:0]        r_reg;
    logic [COLOR_W-1:0]      color_reg;
    logic [TIDX_W-1:0]       tcol_reg, trow_reg;

    // geometry and row walk
    coord_t               x0_reg, x1m1_reg, y0_reg, y1m1_reg;
    coord_t               yy_reg, row_to_reg;
    logic [SQ_IN_W-1:0]   rr_reg, dy2_reg;
    logic [RAD_W-1:0]     dy_abs_reg;
    coord_t               first_reg, last_reg;
    logic                 hit_reg;
    logic [CNT_W-1:0]     cnt_reg;

    // pending span and output beat
    logic                 pend_valid_reg;
    logic [OUT_W-1:0]     pend_row_reg, pend_first_reg, pend_last_reg;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_row_reg, out_first_reg, out_last_reg;
    logic [COLOR_W-1:0]   out_color_reg;
    logic                 out_final_reg;

    logic [SQ_OUT_W-1:0]  sq_root;
    logic                 sq_done;

    coord_t cx_ext, cy_ext, r_ext;
    coord_t x0_c, x_end, fw_ext, x1_c, y0_c, y_end, fh_ext, y1_c;
    coord_t top_c, bot_c, dy_c, dy_neg, dx_ext, left_c, right_c, first_c, last_c;
    logic   out_free;

    assign cx_ext = coord_t'(cx_reg);
    assign cy_ext = coord_t'(cy_reg);
    assign r_ext  = coord_t'(r_reg);

    // tile rectangle cut at the frame edges
    always_comb
    begin
        x0_c   = coord_t'(tcol_reg) * TILE_C;
        x_end  = x0_c + TILE_C;
        fw_ext = coord_t'(fw_reg);
        x1_c   = (x_end < fw_ext) ? x_end : fw_ext;
        y0_c   = coord_t'(trow_reg) * TILE_C;
        y_end  = y0_c + TILE_C;
        fh_ext = coord_t'(fh_reg);
        y1_c   = (y_end < fh_ext) ? y_end : fh_ext;
    end

    // circle rows inside the tile
    always_comb
    begin
        top_c = cy_ext - r_ext;
        bot_c = cy_ext + r_ext;
        if (top_c < y0_reg)
        begin
            top_c = y0_reg;
        end
        if (bot_c > y1m1_reg)
        begin
            bot_c = y1m1_reg;
        end
    end

    // row offset magnitude
    always_comb
    begin
        dy_c   = yy_reg - cy_ext;
        dy_neg = -dy_c;
    end

    // span clipped to the tile columns
    always_comb
    begin
        dx_ext  = coord_t'(sq_root);
        left_c  = cx_ext - dx_ext;
        right_c = cx_ext + dx_ext;
        first_c = (left_c < x0_reg) ? x0_reg : left_c;
        last_c  = (right_c > x1m1_reg) ? x1m1_reg : right_c;
    end

    assign out_free = !out_valid_reg || out_ready;

    // frame size configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FRAME_WIDTH_RST;
            fh_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  fw_reg <= cfg_data;
                REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // item capture, geometry and per-row arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cx_reg    <= center_x;
            cy_reg    <= center_y;
            r_reg     <= radius;
            color_reg <= fill_color;
            tcol_reg  <= tile_col;
            trow_reg  <= tile_row;
        end
        if (cmd.setup)
        begin
            x0_reg   <= x0_c;
            x1m1_reg <= x1_c - coord_t'(1);
            y0_reg   <= y0_c;
            y1m1_reg <= y1_c - coord_t'(1);
            rr_reg   <= SQ_IN_W'(r_reg) * SQ_IN_W'(r_reg);
        end
        if (cmd.row_init)
        begin
            yy_reg     <= top_c;
            row_to_reg <= bot_c;
        end
        else if (cmd.next_row)
        begin
            yy_reg <= yy_reg + coord_t'(1);
        end
        if (cmd.dy_calc)
        begin
            dy_abs_reg <= dy_c[COORD_W-1] ? dy_neg[RAD_W-1:0] : dy_c[RAD_W-1:0];
        end
        if (cmd.mul)
        begin
            dy2_reg <= SQ_IN_W'(dy_abs_reg) * SQ_IN_W'(dy_abs_reg);
        end
        if (cmd.clip)
        begin
            first_reg <= first_c;
            last_reg  <= last_c;
            hit_reg   <= (first_c <= last_c);
        end
        if (cmd.push_span)
        begin
            pend_row_reg   <= yy_reg[OUT_W-1:0];
            pend_first_reg <= first_reg[OUT_W-1:0];
            pend_last_reg  <= last_reg[OUT_W-1:0];
        end
    end

    // span count and pending flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.row_init)
        begin
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.push_span)
        begin
            cnt_reg        <= cnt_reg + 1'b1;
            pend_valid_reg <= 1'b1;
        end
        else if (cmd.emit_final)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.push_span || cmd.emit_final) && pend_valid_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if ((cmd.push_span || cmd.emit_final) && pend_valid_reg)
        begin
            out_row_reg   <= pend_row_reg;
            out_first_reg <= pend_first_reg;
            out_last_reg  <= pend_last_reg;
            out_color_reg <= color_reg;
            out_final_reg <= cmd.emit_final;
        end
    end

    tcsf_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sq_start),
        .radicand (rr_reg - dy2_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    // status to the controller
    always_comb
    begin
        stat.row_done   = (yy_reg > row_to_reg) || (cnt_reg == CNT_W'(MAX_SPANS));
        stat.sq_done    = sq_done;
        stat.span_hit   = hit_reg;
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = out_free;
    end

    assign out_valid  = out_valid_reg;
    assign span_row   = out_row_reg;
    assign span_first = out_first_reg;
    assign span_last  = out_last_reg;
    assign span_color = out_color_reg;
    assign final_span = out_final_reg;

endmodule

// File: hdl/tcsf_ctrl.sv
// controller: sequences setup, the row walk and the final flush of one circle
module tcsf_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcsf_pkg::dp_stat_t  stat,
    output tcsf_pkg::dp_cmd_t   cmd
);
    import tcsf_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_RINIT = 4'd2;
    localparam logic [3:0] S_RCHK  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_SQLD  = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_FLUSH = 4'd8;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_RINIT;
            end
            S_RINIT:
            begin
                cmd.row_init = 1'b1;
                state_next   = S_RCHK;
            end
            S_RCHK:
            begin
                if (stat.row_done)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.dy_calc = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SQLD;
            end
            S_SQLD:
            begin
                cmd.sq_start = 1'b1;
                state_next   = S_SQRT;
            end
            S_SQRT:
            begin
                if (stat.sq_done)
                begin
                    cmd.clip   = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // a new span pushes the older pending one out as a beat
                if (!stat.span_hit)
                begin
                    cmd.next_row = 1'b1;
                    state_next   = S_RCHK;
                end
                else if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.push_span = 1'b1;
                    cmd.next_row  = 1'b1;
                    state_next    = S_RCHK;
                end
            end
            S_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// File: hdl/tiled_circle_span_fill_top.sv
// top level of the tiled circle span fill block
//
// Usage: one input beat carries a filled circle (center, radius, color) and a tile
// index. The block emits the horizontal spans of the circle that fall inside the
// tile, cut at the frame size, top row first; the last span carries final_span.
// A circle that misses the tile emits no beat at all.
// Input channel in_valid/in_ready, output channel out_valid/out_ready. Frame size
// is written on the cfg_we/cfg_index/cfg_data port while the block is idle.
// Sequence: an item passes SETUP and RINIT, then walks the circle rows inside
// the tile (at most TILE_SIZE); each row passes RCHK, MUL, SQLD, SQRT and EMIT,
// taking its root from the shared two-bits-per-cycle square root unit. A span
// leaves once the next span (or the end of the item) settles its flag.
// One item is worked at a time; in_ready is high only between items, and the
// next item is taken while the last beat still sits in the output register.
// Reset: frame size returns to 640 x 480, no beat is pending.
// Stall: a held output beat stops the row walk when the next span is ready.
module tiled_circle_span_fill_top
#(
    parameter int TILE_SIZE = tcsf_pkg::TILE_SIZE_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tcsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcsf_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [tcsf_pkg::POS_W-1:0]   center_x,
    input  logic signed [tcsf_pkg::POS_W-1:0]   center_y,
    input  logic [tcsf_pkg::RAD_W-1:0]          radius,
    input  logic [tcsf_pkg::COLOR_W-1:0]        fill_color,
    input  logic [tcsf_pkg::TIDX_W-1:0]         tile_col,
    input  logic [tcsf_pkg::TIDX_W-1:0]         tile_row,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tcsf_pkg::OUT_W-1:0]          span_row,
    output logic [tcsf_pkg::OUT_W-1:0]          span_first,
    output logic [tcsf_pkg::OUT_W-1:0]          span_last,
    output logic [tcsf_pkg::COLOR_W-1:0]        span_color,
    output logic                                final_span
);
    import tcsf_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tcsf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcsf_datapath #(.TILE_SIZE(TILE_SIZE)) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .fill_color (fill_color),
        .tile_col   (tile_col),
        .tile_row   (tile_row),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .span_row   (span_row),
        .span_first (span_first),
        .span_last  (span_last),
        .span_color (span_color),
        .final_span (final_span)
    );

endmodule

// File: hdl/tcsf_checker.sv
// port-level checker of the tiled circle span fill block and its bind
module tcsf_checker
#(
    parameter int TILE_SIZE = tcsf_pkg::TILE_SIZE_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [tcsf_pkg::OUT_W-1:0]     span_row,
    input  logic [tcsf_pkg::OUT_W-1:0]     span_first,
    input  logic [tcsf_pkg::OUT_W-1:0]     span_last,
    input  logic [tcsf_pkg::COLOR_W-1:0]   span_color,
    input  logic                           final_span
);
    import tcsf_pkg::*;

    // an accepted item keeps the input closed for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    // a stalled beat holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(span_row) && $stable(span_first)
            && $stable(span_last) && $stable(span_color) && $stable(final_span))
        else $error("stalled span beat changed");

    // a span never spans more columns than one tile
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (OUT_W'(span_last - span_first) < OUT_W'(TILE_SIZE)))
        else $error("span wider than a tile");

endmodule

bind tiled_circle_span_fill_top tcsf_checker #(.TILE_SIZE(TILE_SIZE)) u_tcsf_checker (.*);

// File: dv/tb_tiled_circle_span_fill_top.sv
`timescale 1ns / 100ps
// self-checking testbench of the tiled circle span fill block
module tb_tiled_circle_span_fill_top;
    import tcsf_pkg::*;

    localparam int TILE_SIZE       = TILE_SIZE_DEF;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 35;
    // settle time covers the worst item walk over a full tile, plus margin
    localparam int SETTLE_CYCLES   = 4 + 10 * TILE_SIZE + 76;
    localparam int CYCLE_LIMIT     = 1_500_000;
    localparam int TIDX_MAX        = (1 << TIDX_W) - 1;

    // register indexes the block has no register behind
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef struct packed {
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic [RAD_W-1:0]        radius;
        logic [COLOR_W-1:0]      color;
        logic [TIDX_W-1:0]       tcol;
        logic [TIDX_W-1:0]       trow;
    } circle_t;

    typedef struct packed {
        logic [OUT_W-1:0]   row;
        logic [OUT_W-1:0]   first;
        logic [OUT_W-1:0]   last;
        logic [COLOR_W-1:0] color;
        logic               fin;
    } span_t;

    // expected spans of every accepted circle, checked in order
    class circle_span_board;
        logic [CFG_W-1:0] frame_w;
        logic [CFG_W-1:0] frame_h;
        span_t            spans_due[$];
        int               mismatch_count;

        function new();
            frame_w        = FRAME_WIDTH_RST;
            frame_h        = FRAME_HEIGHT_RST;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_FRAME_WIDTH)
                frame_w = val;
            else if (idx == REG_FRAME_HEIGHT)
                frame_h = val;
        endfunction

        // floor square root, one result bit at a time from the top
        function longint root_floor(longint v);
            longint res;
            longint trial;
            res = 0;
            for (int b = RAD_W; b >= 0; b--)
            begin
                trial = res + (longint'(1) << b);
                if (trial * trial <= v)
                    res = trial;
            end
            return res;
        endfunction

        // walk the circle rows inside the clipped tile and queue the spans
        function void note_circle(circle_t c);
            longint cx, cy, r, fw, fh;
            longint x0, y0, x1, y1, top, bottom, yy, dy, d2, dx, lo, hi;
            int     n;
            span_t  s;
            cx = longint'($signed(c.cx));
            cy = longint'($signed(c.cy));
            r  = longint'(c.radius);
            fw = longint'(frame_w);
            fh = longint'(frame_h);
            x0 = longint'(c.tcol) * TILE_SIZE;
            y0 = longint'(c.trow) * TILE_SIZE;
            x1 = (x0 + TILE_SIZE < fw) ? x0 + TILE_SIZE : fw;
            y1 = (y0 + TILE_SIZE < fh) ? y0 + TILE_SIZE : fh;
            top    = (cy - r > y0) ? cy - r : y0;
            bottom = (cy + r < y1 - 1) ? cy + r : y1 - 1;
            n = 0;
            for (yy = top; yy <= bottom && n < MAX_SPANS; yy++)
            begin
                dy = yy - cy;
                d2 = r * r - dy * dy;
                dx = root_floor(d2 < 0 ? 0 : d2);
                lo = (cx - dx > x0) ? cx - dx : x0;
                hi = (cx + dx < x1 - 1) ? cx + dx : x1 - 1;
                // rows whose clipped span is empty give no beat
                if (lo <= hi)
                begin
                    s.row   = OUT_W'(yy);
                    s.first = OUT_W'(lo);
                    s.last  = OUT_W'(hi);
                    s.color = c.color;
                    s.fin   = 1'b0;
                    spans_due = {spans_due, s};
                    n++;
                end
            end
            // flag the last span of this circle
            if (n > 0)
            begin
                s = spans_due.pop_back();
                s.fin = 1'b1;
                spans_due = {spans_due, s};
            end
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_span(span_t got);
            span_t want;
            if (spans_due.size() == 0)
            begin
                $error("span beat with no span due: row %0d first %0d last %0d",
                       got.row, got.first, got.last);
                mismatch_count++;
                return;
            end
            want = spans_due.pop_front();
            match_field("span_row", 32'(want.row), 32'(got.row));
            match_field("span_first", 32'(want.first), 32'(got.first));
            match_field("span_last", 32'(want.last), 32'(got.last));
            match_field("span_color", want.color, got.color);
            match_field("final_span", 32'(want.fin), 32'(got.fin));
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [POS_W-1:0] center_x;
    logic signed [POS_W-1:0] center_y;
    logic [RAD_W-1:0]        radius;
    logic [COLOR_W-1:0]      fill_color;
    logic [TIDX_W-1:0]       tile_col;
    logic [TIDX_W-1:0]       tile_row;
    logic                    out_valid;
    logic                    out_ready;
    logic [OUT_W-1:0]        span_row;
    logic [OUT_W-1:0]        span_first;
    logic [OUT_W-1:0]        span_last;
    logic [COLOR_W-1:0]      span_color;
    logic                    final_span;

    circle_span_board span_board = new();
    int               idle_pct  = 0;
    int               stall_pct = 0;
    int               cycle_count;

    tiled_circle_span_fill_top #(.TILE_SIZE(TILE_SIZE)) DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .fill_color (fill_color),
        .tile_col   (tile_col),
        .tile_row   (tile_row),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .span_row   (span_row),
        .span_first (span_first),
        .span_last  (span_last),
        .span_color (span_color),
        .final_span (final_span)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // span receiver with random back-pressure
    initial
    begin
        span_t got;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.row   = span_row;
                got.first = span_first;
                got.last  = span_last;
                got.color = span_color;
                got.fin   = final_span;
                span_board.check_span(got);
            end
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic circle_t make_circle(int cx, int cy, int r, logic [31:0] color,
                                            int tc, int tr);
        circle_t c;
        c.cx     = POS_W'(cx);
        c.cy     = POS_W'(cy);
        c.radius = RAD_W'(r);
        c.color  = color;
        c.tcol   = TIDX_W'(tc);
        c.trow   = TIDX_W'(tr);
        return c;
    endfunction

    // mostly circles aimed at a tile inside the frame, some raw noise
    function automatic circle_t random_circle(logic [CFG_W-1:0] fw, logic [CFG_W-1:0] fh);
        circle_t c;
        int      col_lim, row_lim, r;
        c.color = $urandom;
        if ($urandom_range(0, 99) < 20)
        begin
            c.cx     = POS_W'($urandom);
            c.cy     = POS_W'($urandom);
            c.radius = RAD_W'($urandom);
            c.tcol   = TIDX_W'($urandom);
            c.trow   = TIDX_W'($urandom);
        end
        else
        begin
            col_lim = (int'(fw) - 1) / TILE_SIZE;
            row_lim = (int'(fh) - 1) / TILE_SIZE;
            col_lim = (col_lim < 0) ? 0 : (col_lim > TIDX_MAX ? TIDX_MAX : col_lim);
            row_lim = (row_lim < 0) ? 0 : (row_lim > TIDX_MAX ? TIDX_MAX : row_lim);
            c.tcol = TIDX_W'($urandom_range(0, col_lim));
            c.trow = TIDX_W'($urandom_range(0, row_lim));
            r = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 1023))
                                            : int'($urandom_range(0, 40));
            c.radius = RAD_W'(r);
            c.cx = POS_W'(int'(c.tcol) * TILE_SIZE
                          + int'($urandom_range(0, TILE_SIZE + 2 * r + 8)) - r - 4);
            c.cy = POS_W'(int'(c.trow) * TILE_SIZE
                          + int'($urandom_range(0, TILE_SIZE + 2 * r + 8)) - r - 4);
        end
        return c;
    endfunction

    // offer one circle beat, with a random gap ahead of it
    task automatic send_circle(circle_t c);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        center_x   <= c.cx;
        center_y   <= c.cy;
        radius     <= c.radius;
        fill_color <= c.color;
        tile_col   <= c.tcol;
        tile_row   <= c.trow;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        span_board.note_circle(c);
    endtask

    // hold input until every span is out and the last row walk is over
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (span_board.spans_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        span_board.write_reg(idx, val);
    endtask

    // frame size, sometimes followed by a write to an unused index
    task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        if ($urandom_range(0, 1) == 1)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        circle_t          directed_q[$];
        logic [CFG_W-1:0] phase_w [PHASES];
        logic [CFG_W-1:0] phase_h [PHASES];

        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= REG_FRAME_WIDTH;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        center_x   <= '0;
        center_y   <= '0;
        radius     <= '0;
        fill_color <= '0;
        tile_col   <= '0;
        tile_row   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed circles at the reset frame size of 640 x 480
        directed_q = {directed_q, make_circle(16, 16, 0, 32'hFFFF_FFFF, 0, 0)};
        directed_q = {directed_q, make_circle(16, 16, 10, 32'h0000_0000, 0, 0)};
        directed_q = {directed_q, make_circle(0, 0, 1023, 32'h1234_5678, 0, 0)};
        directed_q = {directed_q, make_circle(500, 300, 5, 32'hDEAD_BEEF, 0, 0)};
        directed_q = {directed_q, make_circle(100, 100, 50, 32'h0F0F_0F0F, 63, 63)};
        directed_q = {directed_q, make_circle(630, 470, 20, 32'hF0F0_F0F0, 19, 14)};
        directed_q = {directed_q, make_circle(-4096, -4096, 1023, 32'h8000_0001, 0, 0)};
        directed_q = {directed_q, make_circle(4095, 4095, 1023, 32'h7FFF_FFFE, 63, 63)};
        directed_q = {directed_q, make_circle(-5, 16, 10, 32'hAAAA_5555, 0, 0)};
        directed_q = {directed_q, make_circle(-10, -10, 30, 32'h5555_AAAA, 0, 0)};
        directed_q = {directed_q, make_circle(40, -3, 6, 32'h0000_00FF, 1, 0)};
        directed_q = {directed_q, make_circle(639, 479, 1, 32'hFF00_0000, 19, 14)};
        directed_q = {directed_q, make_circle(320, 240, 1023, 32'h00FF_FF00, 10, 7)};
        directed_q = {directed_q, make_circle(-4096, 4095, 0, 32'hCAFE_F00D, 0, 63)};
        directed_q = {directed_q, make_circle(16, 50, 16, 32'h1111_1111, 0, 1)};
        directed_q = {directed_q, make_circle(31, 31, 1, 32'h2222_2222, 0, 0)};
        directed_q = {directed_q, make_circle(32, 16, 0, 32'h3333_3333, 0, 0)};
        directed_q = {directed_q, make_circle(0, 0, 0, 32'hA5A5_A5A5, 0, 0)};
        directed_q = {directed_q, make_circle(4095, -4096, 512, 32'h5A5A_5A5A, 42, 21)};
        directed_q = {directed_q, make_circle(-1, 16, 1, 32'h4444_4444, 0, 0)};
        directed_q = {directed_q, make_circle(600, 40, 100, 32'h6666_6666, 20, 1)};
        foreach (directed_q[i])
            send_circle(directed_q[i]);

        // frame size per random phase, extremes among them
        phase_w = '{CFG_W'(640), CFG_W'(2048), CFG_W'(4095), CFG_W'(1),
                    CFG_W'(0), CFG_W'(640), CFG_W'(0), CFG_W'(33)};
        phase_h = '{CFG_W'(480), CFG_W'(2048), CFG_W'(4095), CFG_W'(1),
                    CFG_W'(480), CFG_W'(0), CFG_W'(0), CFG_W'(2047)};
        phase_w[6] = CFG_W'($urandom_range(1, 2048));
        phase_h[6] = CFG_W'($urandom_range(1, 2048));

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            set_frame(phase_w[p], phase_h[p]);
            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 56;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 56;
                end
                default:
                begin
                    idle_pct  = 13;
                    stall_pct = 13;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                send_circle(random_circle(phase_w[p], phase_h[p]));
                // now and then let the block drain completely
                if ($urandom_range(0, 29) == 0)
                    wait_idle();
            end
        end
        wait_idle();

        if (span_board.mismatch_count == 0 && span_board.spans_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
hdl/tcsf_pkg.sv
hdl/tcsf_isqrt.sv
hdl/tcsf_datapath.sv
hdl/tcsf_ctrl.sv
hdl/tiled_circle_span_fill_top.sv
hdl/tcsf_checker.sv
dv/tb_tiled_circle_span_fill_top.sv
